### src/clump_class_border_accumulator_macros.svh
// Assertion macros shared by the border accumulator RTL.
`ifndef CLUMP_CLASS_BORDER_ACCUMULATOR_MACROS_SVH
`define CLUMP_CLASS_BORDER_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CCBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccba check failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CCBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccba check failed: next-cycle implication");

`endif

### src/ccba_pkg.sv
// Constants, types and helper functions of the clump class border accumulator.
package ccba_pkg;

   localparam int LABELS    = 4096;
   localparam int SUM_WIDTH = 40;
   localparam int ADDR_W    = $clog2(LABELS);

   localparam int LABEL_W     = 12;
   localparam int LIMIT_W     = 13;
   localparam int STEP_W      = 16;
   localparam int OUT_SUM_W   = 40;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // request operations
   localparam logic [OP_W-1:0] OP_SET_CLASS  = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_SUMS  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_EDGES  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_STEP      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_STEP      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LABEL_LIMIT = 8'd3;

   // register reset values
   localparam logic               RST_ZERO_EDGES  = 1'b0;
   localparam logic [STEP_W-1:0]  RST_X_STEP      = 16'd256;
   localparam logic [STEP_W-1:0]  RST_Y_STEP      = 16'd256;
   localparam logic [LIMIT_W-1:0] RST_LABEL_LIMIT = 13'd4096;

   // neighbour visiting order
   localparam logic [1:0] SIDE_LEFT  = 2'd0;
   localparam logic [1:0] SIDE_UP    = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;
   localparam logic [1:0] SIDE_DOWN  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SIDE,
      ST_WRITE,
      ST_REPLY
   } state_type;

   function automatic logic label_ok(logic [LABEL_W-1:0] lbl);
      return 32'(lbl) < LABELS;
   endfunction

   function automatic logic [ADDR_W-1:0] to_addr(logic [LABEL_W-1:0] lbl);
      return ADDR_W'(lbl);
   endfunction

   function automatic logic [SUM_WIDTH-1:0] sat_add(logic [SUM_WIDTH-1:0] a,
                                                    logic [STEP_W-1:0] b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + (SUM_WIDTH+1)'(b);
      return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
   endfunction

endpackage

### src/clump_class_border_accumulator.sv
// Per-label border and class-border length accumulator over a four-neighbour window.
//
// The block keeps, for every segment label, a saturating border length sum, a
// saturating class-border sum and a class flag. A request with op 0 loads a label's
// class flag, op 1 accumulates one pixel window into the centre label's sums, op 2
// returns one response with a label's sums and flag, and op 3 clears a label's entry.
// All state lies in two single-port-write, one-port-read memories with a registered
// read: one holds both sums of a label, the other the class flags. Requests are handled
// one at a time by a small sequencer. Ops 0 and 3, and an op 1 whose centre is label
// zero or not below the label limit, are done in the accept cycle. An op 1 that counts
// steps through the states in order: the accept cycle reads the centre entry, ST_LOOK
// loads it, ST_SIDE walks the left, up, right and down neighbours (one class-flag read
// and one saturating add per neighbour), and ST_WRITE writes the entry back. An op 2
// passes through ST_LOOK and ST_REPLY, which waits for the response register to drain;
// the next request is taken while a response still waits. After reset the block clears
// both memories, one entry a cycle, before it takes its first request; configuration
// writes are taken at any time and should come only when idle.
`include "clump_class_border_accumulator_macros.svh"

module clump_class_border_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ccba_pkg::OP_W-1:0]              req_op,
   input  logic [ccba_pkg::LABEL_W-1:0]           req_center_label,
   input  logic [ccba_pkg::LABEL_W-1:0]           req_left_label,
   input  logic [ccba_pkg::LABEL_W-1:0]           req_right_label,
   input  logic [ccba_pkg::LABEL_W-1:0]           req_up_label,
   input  logic [ccba_pkg::LABEL_W-1:0]           req_down_label,
   input  logic                                   req_class_bit,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ccba_pkg::LABEL_W-1:0]           rsp_result_label,
   output logic [ccba_pkg::OUT_SUM_W-1:0]         rsp_border_total,
   output logic [ccba_pkg::OUT_SUM_W-1:0]         rsp_class_border_total,
   output logic                                   rsp_is_class,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ccba_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ccba_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SW = ccba_pkg::SUM_WIDTH;
   localparam int AW = ccba_pkg::ADDR_W;
   localparam int LW = ccba_pkg::LABEL_W;

   // configuration registers
   logic                              zero_edges_ff;
   logic [ccba_pkg::STEP_W-1:0]       x_step_ff;
   logic [ccba_pkg::STEP_W-1:0]       y_step_ff;
   logic [ccba_pkg::LIMIT_W-1:0]      label_limit_ff;

   // sequencer state
   ccba_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [1:0]          side_ff, side_in;

   // captured request
   logic [ccba_pkg::OP_W-1:0] op_ff;
   logic [LW-1:0]             center_ff, left_ff, right_ff, up_ff, down_ff;
   logic                      ok_ff;

   // working copy of the centre entry
   logic [SW-1:0] work_border_ff, work_border_in;
   logic [SW-1:0] work_class_ff, work_class_in;
   logic          centre_flag_ff, centre_flag_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_load;
   logic [LW-1:0]                  rsp_label_ff;
   logic [ccba_pkg::OUT_SUM_W-1:0] rsp_border_ff, rsp_class_ff;
   logic                           rsp_flag_ff;

   // memories
   logic [2*SW-1:0] sum_mem [ccba_pkg::LABELS];
   logic            flag_mem [ccba_pkg::LABELS];
   logic [2*SW-1:0] sum_rd_ff;
   logic            flag_rd_ff;
   logic            sum_we, flag_we;
   logic [AW-1:0]   sum_wa, flag_wa, sum_ra, flag_ra;
   logic [2*SW-1:0] sum_wd;
   logic            flag_wd;

   // datapath helpers
   logic                        accept;
   logic                        req_ok;
   logic                        req_active;
   logic [LW-1:0]               nbr, nbr_next;
   logic [1:0]                  side_next;
   logic [ccba_pkg::STEP_W-1:0] step;
   logic                        counts;
   logic                        nbr_in_class;

   // check helpers
   logic                        read_taken;
   logic                        clear_taken;
   logic                        last_side;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ccba_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_ok    = ccba_pkg::label_ok(req_center_label);
   assign req_active = req_ok && (req_center_label != '0)
                       && ({1'b0, req_center_label} < label_limit_ff);

   // neighbour of the current side and of the one after it
   assign side_next = side_ff + 2'd1;

   always_comb begin
      unique case (side_ff)
         ccba_pkg::SIDE_LEFT:  nbr = left_ff;
         ccba_pkg::SIDE_UP:    nbr = up_ff;
         ccba_pkg::SIDE_RIGHT: nbr = right_ff;
         ccba_pkg::SIDE_DOWN:  nbr = down_ff;
         default:              nbr = left_ff;
      endcase
      unique case (side_next)
         ccba_pkg::SIDE_LEFT:  nbr_next = left_ff;
         ccba_pkg::SIDE_UP:    nbr_next = up_ff;
         ccba_pkg::SIDE_RIGHT: nbr_next = right_ff;
         ccba_pkg::SIDE_DOWN:  nbr_next = down_ff;
         default:              nbr_next = left_ff;
      endcase
   end

   // left and right move by x_step, up and down by y_step
   assign step = side_ff[0] ? y_step_ff : x_step_ff;

   // a differing neighbour counts unless it is label zero with zero edges off
   assign counts = (nbr != center_ff) && !((nbr == '0) && !zero_edges_ff);
   assign nbr_in_class = ccba_pkg::label_ok(nbr) && flag_rd_ff;

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_edges_ff  <= ccba_pkg::RST_ZERO_EDGES;
         x_step_ff      <= ccba_pkg::RST_X_STEP;
         y_step_ff      <= ccba_pkg::RST_Y_STEP;
         label_limit_ff <= ccba_pkg::RST_LABEL_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ccba_pkg::CSR_ZERO_EDGES:  zero_edges_ff  <= csr_wdata[0];
            ccba_pkg::CSR_X_STEP:      x_step_ff      <= csr_wdata;
            ccba_pkg::CSR_Y_STEP:      y_step_ff      <= csr_wdata;
            ccba_pkg::CSR_LABEL_LIMIT: label_limit_ff <= csr_wdata[ccba_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: next state, memory ports and working values
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      side_in        = side_ff;
      work_border_in = work_border_ff;
      work_class_in  = work_class_ff;
      centre_flag_in = centre_flag_ff;
      rsp_load       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      sum_we  = 1'b0;
      sum_wa  = center_ff[AW-1:0];
      sum_wd  = {work_class_ff, work_border_ff};
      flag_we = 1'b0;
      flag_wa = ccba_pkg::to_addr(req_center_label);
      flag_wd = 1'b0;
      sum_ra  = ccba_pkg::to_addr(req_center_label);
      flag_ra = ccba_pkg::to_addr(req_center_label);

      unique case (state_ff)
         ccba_pkg::ST_CLEAR: begin
            // sweep both memories to zero
            sum_we  = 1'b1;
            sum_wa  = clr_ff;
            sum_wd  = '0;
            flag_we = 1'b1;
            flag_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(ccba_pkg::LABELS - 1)) begin
               state_in = ccba_pkg::ST_IDLE;
            end
         end
         ccba_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  ccba_pkg::OP_SET_CLASS: begin
                     flag_we = req_ok;
                     flag_wd = req_class_bit;
                  end
                  ccba_pkg::OP_CLEAR: begin
                     flag_we = req_ok;
                     sum_we  = req_ok;
                     sum_wa  = ccba_pkg::to_addr(req_center_label);
                     sum_wd  = '0;
                  end
                  ccba_pkg::OP_ACCUMULATE: begin
                     if (req_active) begin
                        state_in = ccba_pkg::ST_LOOK;
                     end
                  end
                  default: begin
                     state_in = ccba_pkg::ST_LOOK;
                  end
               endcase
            end
         end
         ccba_pkg::ST_LOOK: begin
            // centre entry has arrived; fetch the first neighbour's flag
            work_border_in = sum_rd_ff[SW-1:0];
            work_class_in  = sum_rd_ff[2*SW-1:SW];
            centre_flag_in = flag_rd_ff;
            flag_ra        = ccba_pkg::to_addr(left_ff);
            side_in        = ccba_pkg::SIDE_LEFT;
            state_in = (op_ff == ccba_pkg::OP_ACCUMULATE) ? ccba_pkg::ST_SIDE
                                                           : ccba_pkg::ST_REPLY;
         end
         ccba_pkg::ST_SIDE: begin
            // one neighbour a cycle: add the step and prefetch the next flag
            flag_ra = ccba_pkg::to_addr(nbr_next);
            if (counts) begin
               work_border_in = ccba_pkg::sat_add(work_border_ff, step);
               if (!centre_flag_ff && nbr_in_class) begin
                  work_class_in = ccba_pkg::sat_add(work_class_ff, step);
               end
            end
            side_in = side_next;
            if (side_ff == ccba_pkg::SIDE_DOWN) begin
               state_in = ccba_pkg::ST_WRITE;
            end
         end
         ccba_pkg::ST_WRITE: begin
            sum_we   = 1'b1;
            state_in = ccba_pkg::ST_IDLE;
         end
         ccba_pkg::ST_REPLY: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ccba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccba_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         side_ff      <= ccba_pkg::SIDE_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         center_ff <= req_center_label;
         left_ff   <= req_left_label;
         right_ff  <= req_right_label;
         up_ff     <= req_up_label;
         down_ff   <= req_down_label;
         ok_ff     <= req_ok;
      end
      work_border_ff <= work_border_in;
      work_class_ff  <= work_class_in;
      centre_flag_ff <= centre_flag_in;
      if (rsp_load) begin
         rsp_label_ff  <= center_ff;
         rsp_border_ff <= ok_ff ? ccba_pkg::OUT_SUM_W'(work_border_ff) : '0;
         rsp_class_ff  <= ok_ff ? ccba_pkg::OUT_SUM_W'(work_class_ff) : '0;
         rsp_flag_ff   <= ok_ff && centre_flag_ff;
      end
   end

   // sum memory: both sums of a label in one word
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   // class flag memory
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_label       = rsp_label_ff;
   assign rsp_border_total       = rsp_border_ff;
   assign rsp_class_border_total = rsp_class_ff;
   assign rsp_is_class           = rsp_flag_ff;

   assign read_taken  = accept && (req_op == ccba_pkg::OP_READ_SUMS);
   assign clear_taken = accept && (req_op == ccba_pkg::OP_CLEAR);
   assign last_side   = (state_ff == ccba_pkg::ST_SIDE) && (side_ff == ccba_pkg::SIDE_DOWN);

   `CCBA_ASSERT_NEXT(a_read_goes_to_look, read_taken, state_ff == ccba_pkg::ST_LOOK)
   `CCBA_ASSERT_NOW(a_rsp_from_reply, $rose(rsp_valid_ff), $past(state_ff) == ccba_pkg::ST_REPLY)
   `CCBA_ASSERT_NEXT(a_last_side_writes, last_side, state_ff == ccba_pkg::ST_WRITE)
   `CCBA_ASSERT_NOW(a_sum_write_single, sum_we && (state_ff == ccba_pkg::ST_IDLE), clear_taken)

endmodule
